// ===== rtl/sorted_priority_queue_top_macros.svh =====
// Assertion macros used by the sorted priority queue top module.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

// Concurrent assertion sampled on the clock, muted while reset is applied.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication checked in the cycle after its condition, for results that follow an accepted word.
`define SPQ_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Types and constants of the sorted priority queue.
package spq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CountW = 5;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic                     mode;
    logic signed [DataW-1:0]  item_data;
    logic signed [PrioW-1:0]  item_priority;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DataW-1:0]  removed_data;
    logic                     head_valid;
    logic signed [DataW-1:0]  head_data;
    logic signed [PrioW-1:0]  head_priority;
    logic [CountW-1:0]        entry_count;
  } out_t;

  // One stored entry of a cell.
  typedef struct packed {
    logic                     valid;
    logic signed [DataW-1:0]  data;
    logic signed [PrioW-1:0]  prio;
  } entry_t;

  // Command broadcast to every cell for the current word.
  typedef struct packed {
    logic                     push_en;
    logic                     pop_en;
    logic signed [DataW-1:0]  data;
    logic signed [PrioW-1:0]  prio;
  } cmd_t;

endpackage

// ===== rtl/sorted_priority_queue_top.sv =====
// Sorted priority queue: a row of DEPTH cells kept in descending priority order.
// It takes one word per cycle while in_ready_o is high: a push or pop is applied to all cells at once in the
// cycle it is accepted (each cell compares its priority against the broadcast one and
// keeps, takes the new entry, or takes a neighbor's entry), and the result word is
// registered, so it appears in the cycle after acceptance. The input is accepted
// whenever the output register is empty or being drained. There is no clearing pass
// after reset; the queue is empty and ready at once.
module sorted_priority_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  spq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output spq_pkg::out_t  out_data_o
);

  `include "sorted_priority_queue_top_macros.svh"

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  spq_pkg::entry_t ent   [DEPTH];
  spq_pkg::entry_t nxt   [DEPTH];
  logic [DEPTH-1:0] ge_v, match_v, hit_v, valid_v;

  spq_pkg::cmd_t   cmd;
  logic            in_acc;
  logic            full, found;
  logic [CntW-1:0] count_q, count_d;
  logic signed [spq_pkg::DataW-1:0] removed;

  logic            out_valid_q;
  spq_pkg::out_t   out_q, out_d;

  logic            push_full, flag_full;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  assign full  = ent[DEPTH-1].valid;
  assign found = |match_v;

  assign cmd.push_en = in_acc && (in_data_i.mode == spq_pkg::MODE_PUSH) && !full;
  assign cmd.pop_en  = in_acc && (in_data_i.mode == spq_pkg::MODE_POP) && found;
  assign cmd.data    = in_data_i.item_data;
  assign cmd.prio    = in_data_i.item_priority;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left, right;
    logic            prev_ge, prev_match;

    if (i == 0) begin : g_first
      assign left       = '0;
      assign prev_ge    = 1'b1;
      assign prev_match = 1'b0;
    end else begin : g_mid
      assign left       = ent[i-1];
      assign prev_ge    = ge_v[i-1];
      assign prev_match = match_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = ent[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .left_i       (left),
      .right_i      (right),
      .prev_ge_i    (prev_ge),
      .prev_match_i (prev_match),
      .ge_o         (ge_v[i]),
      .match_o      (match_v[i]),
      .hit_o        (hit_v[i]),
      .entry_o      (ent[i]),
      .next_o       (nxt[i])
    );

    assign valid_v[i] = ent[i].valid;
  end

  // At most one cell flags the first match, so an AND-OR picks its data.
  always_comb begin
    removed = '0;
    for (int i = 0; i < DEPTH; i++) begin
      removed = removed | (hit_v[i] ? ent[i].data : '0);
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd.push_en) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.pop_en) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    out_d.status       = spq_pkg::ST_DONE;
    out_d.removed_data = '0;
    if (in_data_i.mode == spq_pkg::MODE_POP) begin
      if (found) begin
        out_d.removed_data = removed;
      end else begin
        out_d.status = spq_pkg::ST_NOT_FOUND;
      end
    end else if (full) begin
      out_d.status = spq_pkg::ST_FULL;
    end
    out_d.head_valid    = nxt[0].valid;
    out_d.head_data     = nxt[0].valid ? nxt[0].data : '0;
    out_d.head_priority = nxt[0].valid ? nxt[0].prio : '0;
    out_d.entry_count   = spq_pkg::CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign push_full = in_acc && (in_data_i.mode == spq_pkg::MODE_PUSH) && full;
  assign flag_full = (out_q.status == spq_pkg::ST_FULL);

  `SPQ_ASSERT(a_count_matches_cells, $countones(valid_v) == int'(count_q), "count mismatch")
  `SPQ_ASSERT(a_head_sorted, valid_v[1] |-> (ent[0].prio >= ent[1].prio), "head out of order")
  `SPQ_ASSERT_NEXT(a_full_push, push_full, flag_full && $stable(count_q), "full push missed")

endmodule

// ===== rtl/spq_cell.sv =====
// One queue cell: holds an entry and shifts it toward either neighbor.
module spq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  spq_pkg::cmd_t   cmd_i,
  input  spq_pkg::entry_t left_i,
  input  spq_pkg::entry_t right_i,
  input  logic            prev_ge_i,
  input  logic            prev_match_i,
  output logic            ge_o,
  output logic            match_o,
  output logic            hit_o,
  output spq_pkg::entry_t entry_o,
  output spq_pkg::entry_t next_o
);

  logic                           valid_q;
  logic signed [spq_pkg::DataW-1:0] data_q;
  logic signed [spq_pkg::PrioW-1:0] prio_q;
  spq_pkg::entry_t                  next_d;
  logic                             pop_shift;

  assign entry_o = '{valid: valid_q, data: data_q, prio: prio_q};

  assign ge_o    = valid_q && (prio_q >= cmd_i.prio);
  assign match_o = valid_q && (prio_q == cmd_i.prio);
  // Equal priorities are contiguous, so the first match follows a non-match.
  assign hit_o   = match_o && !prev_match_i;

  // A pop pulls every entry at or behind the removed one forward.
  assign pop_shift = cmd_i.pop_en && !(valid_q && (prio_q > cmd_i.prio));

  always_comb begin
    next_d = entry_o;
    if (cmd_i.push_en && !ge_o) begin
      if (prev_ge_i) begin
        next_d = '{valid: 1'b1, data: cmd_i.data, prio: cmd_i.prio};
      end else begin
        next_d = left_i;
      end
    end else if (pop_shift) begin
      next_d = right_i;
    end
  end

  assign next_o = next_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= next_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= next_d.data;
    prio_q <= next_d.prio;
  end

endmodule

// ===== tb/sorted_priority_queue_top_tb.sv =====
// Self-checking testbench for the sorted priority queue: a directed table, then random words.
module sorted_priority_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH = 16;
  localparam int unsigned RAND_N = 1250;
  localparam int unsigned DIR_N  = 25;
  localparam int unsigned HOLD_OFF_CYCLES = 80;

  typedef struct packed {
    spq_pkg::in_t  stim;
    logic          has_want;
    spq_pkg::out_t want;
  } dir_row_t;

  localparam spq_pkg::out_t NO_WANT = '0;

  logic           clk_i       = 1'b0;
  logic           rst_ni      = 1'b0;
  logic           in_valid_i  = 1'b0;
  logic           in_ready_o;
  spq_pkg::in_t   in_data_i   = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  spq_pkg::out_t  out_data_o;

  // Shadow copy of the queue contents, kept in descending priority order.
  logic signed [spq_pkg::DataW-1:0] slot_val  [QDEPTH];
  logic signed [spq_pkg::PrioW-1:0] slot_rank [QDEPTH];
  int unsigned                      held_n = 0;

  spq_pkg::out_t pending_results [$];
  int unsigned   accepted_n = 0;
  int unsigned   mismatches = 0;
  int unsigned   tx_calm = 0;
  int unsigned   rx_calm = 0;

  dir_row_t dir_tab [DIR_N] = '{
    '{'{spq_pkg::MODE_POP,  32'sh00000000, 16'sh0000}, 1'b1,
      '{spq_pkg::ST_NOT_FOUND, 32'sh0, 1'b0, 32'sh0, 16'sh0, 5'd0}},
    '{'{spq_pkg::MODE_PUSH, 32'sh7FFFFFFF, 16'sh7FFF}, 1'b1,
      '{spq_pkg::ST_DONE, 32'sh0, 1'b1, 32'sh7FFFFFFF, 16'sh7FFF, 5'd1}},
    '{'{spq_pkg::MODE_PUSH, 32'sh80000000, 16'sh8000}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'shFFFFFFFF, 16'shFFFF}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh00000000, 16'sh0000}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh00000001, 16'sh7FFF}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_POP,  32'shDEADBEEF, 16'sh1234}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_POP,  32'sh00000000, 16'sh7FFF}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_POP,  32'shFFFFFFFF, 16'sh8000}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh55555555, 16'sh0001}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'shAAAAAAAA, 16'sh7FFE}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh00000002, 16'shFFFE}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh00000003, 16'sh0000}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh80000001, 16'sh8000}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh0F0F0F0F, 16'sh5555}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'shF0F0F0F0, 16'shAAAA}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh12345678, 16'sh00FF}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh87654321, 16'shFF00}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh00FF00FF, 16'sh1234}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'shFF00FF00, 16'sh8001}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh00000004, 16'sh0000}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh7FFFFFFE, 16'sh7FFE}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_PUSH, 32'sh12345678, 16'sh7FFF}, 1'b1,
      '{spq_pkg::ST_FULL, 32'sh0, 1'b1, 32'sh00000001, 16'sh7FFF, 5'd16}},
    '{'{spq_pkg::MODE_POP,  32'sh00000000, 16'sh0000}, 1'b0, NO_WANT},
    '{'{spq_pkg::MODE_POP,  32'sh00000000, 16'sh7FFF}, 1'b0, NO_WANT}
  };

  sorted_priority_queue_top #(
    .DEPTH(QDEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Applies one word to the shadow queue and returns the result it should produce.
  function automatic spq_pkg::out_t queue_step(spq_pkg::in_t w);
    spq_pkg::out_t r;
    int unsigned   pos;
    int unsigned   k;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    pos = 0;
    if (w.mode == spq_pkg::MODE_PUSH) begin
      if (held_n >= QDEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        while (pos < held_n && $signed(slot_rank[pos]) >= $signed(w.item_priority)) pos++;
        for (k = held_n; k > pos; k--) begin
          slot_val[k]  = slot_val[k-1];
          slot_rank[k] = slot_rank[k-1];
        end
        slot_val[pos]  = w.item_data;
        slot_rank[pos] = w.item_priority;
        held_n++;
      end
    end else begin
      while (pos < held_n && slot_rank[pos] != w.item_priority) pos++;
      if (pos >= held_n) begin
        r.status = spq_pkg::ST_NOT_FOUND;
      end else begin
        r.removed_data = slot_val[pos];
        for (k = pos; k + 1 < held_n; k++) begin
          slot_val[k]  = slot_val[k+1];
          slot_rank[k] = slot_rank[k+1];
        end
        held_n--;
      end
    end
    if (held_n != 0) begin
      r.head_valid    = 1'b1;
      r.head_data     = slot_val[0];
      r.head_priority = slot_rank[0];
    end
    r.entry_count = spq_pkg::CountW'(held_n);
    return r;
  endfunction

  // Mostly no gap or a short one, now and then a long one, and sometimes a calm run.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  // Offers one word, waits for it to be taken, and records the result it should give.
  task automatic send_word(input spq_pkg::in_t w, input logic has_want,
                           input spq_pkg::out_t want);
    int unsigned   gap;
    spq_pkg::out_t predicted;
    gap = idle_len(tx_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = queue_step(w);
    pending_results.push_back(has_want ? want : predicted);
    accepted_n++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  initial begin : stimulus
    spq_pkg::in_t w;
    int unsigned  n;
    int unsigned  phase_left;
    int unsigned  push_pct;
    phase_left = 0;
    push_pct = 50;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (n = 0; n < DIR_N; n++) begin
      send_word(dir_tab[n].stim, dir_tab[n].has_want, dir_tab[n].want);
    end

    // Phases lean toward filling or draining, or stay balanced, so the queue keeps hitting full and empty.
    for (n = 0; n < RAND_N; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(8, 60);
        case ($urandom_range(0, 2))
          0: push_pct = 80;
          1: push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      phase_left--;
      w.mode = ($urandom_range(0, 99) < push_pct) ? spq_pkg::MODE_PUSH : spq_pkg::MODE_POP;
      w.item_data = $urandom();
      if (w.mode == spq_pkg::MODE_POP && held_n != 0 && $urandom_range(0, 3) != 0) begin
        w.item_priority = slot_rank[$urandom_range(0, held_n - 1)];
      end else begin
        case ($urandom_range(0, 9))
          0: w.item_priority = 16'sh7FFF;
          1: w.item_priority = 16'sh8000;
          2, 3: w.item_priority = spq_pkg::PrioW'($urandom());
          default: w.item_priority = spq_pkg::PrioW'($urandom_range(0, 7)) - 16'sd4;
        endcase
      end
      send_word(w, 1'b0, NO_WANT);
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : drain_side
    int unsigned stall;
    bit          held_off;
    held_off = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      // Once, hold the output for a long time so the queue backs up and stalls the input.
      if (!held_off && accepted_n >= 400) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        stall = idle_len(rx_calm);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : check_results
    spq_pkg::out_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got %h", $time, out_data_o);
        end else begin
          want = pending_results.pop_front();
          check_field("status",        want.status,        out_data_o.status);
          check_field("removed_data",  want.removed_data,  out_data_o.removed_data);
          check_field("head_valid",    want.head_valid,    out_data_o.head_valid);
          check_field("head_data",     want.head_data,     out_data_o.head_data);
          check_field("head_priority", want.head_priority, out_data_o.head_priority);
          check_field("entry_count",   want.entry_count,   out_data_o.entry_count);
        end
      end
    end
  end

  initial begin : watchdog
    #(10_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
